// ----- src/dhtc_pkg.sv -----
// Types and constants for the hit time clusterer.
// Used by the cell, the chain and the top level.
`timescale 1ns / 1ps
package dhtc_pkg;

    localparam int unsigned TimeW  = 32;
    localparam int unsigned DepW   = 24;
    localparam int unsigned TrackW = 32;
    localparam int unsigned SumW   = 30;
    localparam int unsigned CnumW  = 6;

    localparam logic [SumW-1:0] SumMax       = {SumW{1'b1}};
    localparam logic [DepW-1:0] ThreshReset  = 24'd20;
    localparam logic [TimeW-1:0] WindowReset = 32'd0;

    localparam logic FuncStep = 1'b0;
    localparam logic FuncEnd  = 1'b1;

    localparam logic CfgThreshold = 1'b0;
    localparam logic CfgWindow    = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [TimeW-1:0]  hit_time;
        logic [DepW-1:0]   deposit;
        logic [TrackW-1:0] track;
    } t_hit;

    typedef struct packed {
        logic              func;
        logic [TimeW-1:0]  step_time;
        logic [DepW-1:0]   total_deposit;
        logic [DepW-1:0]   nonionizing_deposit;
        logic [TrackW-1:0] track_number;
    } t_in_item;

    typedef struct packed {
        logic [CnumW-1:0]  cluster_number;
        logic [TimeW-1:0]  cluster_time;
        logic [TrackW-1:0] top_track;
        logic [SumW-1:0]   deposit_sum;
        logic              overflow;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic ins;
        logic shift;
    } t_chain_ctl;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_DRAIN
    } t_state;

endpackage

// ----- src/detector_hit_time_clusterer_core.sv -----
// Channel  | valid       | stall        | payload
// input    | i_in_valid  | o_in_stall   | i_in_item  (t_in_item)
// output   | o_out_valid | i_out_stall  | o_out_item (t_out_item)
// config   | i_cfg_valid | o_cfg_ready  | i_cfg_index, i_cfg_data
// The sorting chain inserts a step request in place.
// End of event drains the chain one hit a cycle, holding while a closing cluster
// meets a stalled output (a cluster closes in the same cycle that opens the
// next). Inputs stall during the drain.
// Reset clears the chain valid bits, the fill count and the overflow flag.
// Depends on dhtc_pkg and dhtc_chain.
`timescale 1ns / 1ps
module detector_hit_time_clusterer_core
    import dhtc_pkg::*;
#(
    parameter int unsigned MAX_HITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int unsigned CountW = $clog2(MAX_HITS + 1);

    t_state r_state, n_state;
    logic [DepW-1:0]   r_thresh;
    logic [TimeW-1:0]  r_window;
    logic [CountW-1:0] r_count, n_count;
    logic              r_drop, n_drop;

    logic              r_acc_on, n_acc_on;
    logic [TimeW:0]    r_wend, n_wend;
    logic [TimeW-1:0]  r_acc_time, n_acc_time;
    logic [TrackW-1:0] r_acc_track, n_acc_track;
    logic [SumW-1:0]   r_acc_sum, n_acc_sum;
    logic [CnumW-1:0]  r_cnum, n_cnum;

    logic      r_ovalid, n_ovalid;
    t_out_item r_out, n_out;

    t_chain_ctl ctl;
    t_hit       new_hit;
    t_hit       head;
    logic       in_acc;
    logic       out_free;
    logic [DepW-1:0] ion;
    logic            keep;
    logic [SumW:0]   sum_ext;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= ThreshReset;
            r_window <= WindowReset;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CfgThreshold: r_thresh <= i_cfg_data[DepW-1:0];
                CfgWindow:    r_window <= i_cfg_data;
                default:      r_window <= r_window;
            endcase
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_ovalid || !i_out_stall;

    assign ion  = (i_in_item.nonionizing_deposit > i_in_item.total_deposit) ? '0
                : i_in_item.total_deposit - i_in_item.nonionizing_deposit;
    assign keep = (ion >= r_thresh);

    always_comb begin
        new_hit.valid    = 1'b1;
        new_hit.hit_time = i_in_item.step_time;
        new_hit.deposit  = i_in_item.total_deposit;
        new_hit.track    = i_in_item.track_number;
    end

    dhtc_chain #(.Depth(MAX_HITS)) u_chain (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (ctl),
        .i_new  (new_hit),
        .o_head (head)
    );

    assign sum_ext = {1'b0, r_acc_sum} + {{(SumW + 1 - DepW){1'b0}}, head.deposit};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && i_in_item.func == FuncEnd) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!head.valid && (!r_acc_on || out_free)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        ctl.ins     = 1'b0;
        ctl.shift   = 1'b0;
        n_count     = r_count;
        n_drop      = r_drop;
        n_acc_on    = r_acc_on;
        n_wend      = r_wend;
        n_acc_time  = r_acc_time;
        n_acc_track = r_acc_track;
        n_acc_sum   = r_acc_sum;
        n_cnum      = r_cnum;
        n_ovalid    = r_ovalid && i_out_stall;
        n_out       = r_out;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && i_in_item.func == FuncStep && keep) begin
                    if (r_count == CountW'(MAX_HITS)) begin
                        n_drop = 1'b1;
                    end else begin
                        ctl.ins = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                end
                n_cnum = '0;
            end
            ST_DRAIN: begin
                if (head.valid) begin
                    if (!r_acc_on || {1'b0, head.hit_time} <= r_wend) begin
                        ctl.shift = 1'b1;
                        n_count   = r_count - 1'b1;
                        n_acc_on  = 1'b1;
                        if (!r_acc_on) begin
                            n_wend      = {1'b0, head.hit_time} + {1'b0, r_window};
                            n_acc_time  = head.hit_time;
                            n_acc_track = head.track;
                            n_acc_sum   = {{(SumW - DepW){1'b0}}, head.deposit};
                        end else begin
                            if (head.track < r_acc_track) begin
                                n_acc_time  = head.hit_time;
                                n_acc_track = head.track;
                            end
                            n_acc_sum = sum_ext[SumW] ? SumMax : sum_ext[SumW-1:0];
                        end
                    end else if (out_free) begin
                        // close the open cluster, open the next one at the head
                        n_ovalid             = 1'b1;
                        n_out.cluster_number = r_cnum;
                        n_out.cluster_time   = r_acc_time;
                        n_out.top_track      = r_acc_track;
                        n_out.deposit_sum    = r_acc_sum;
                        n_out.overflow       = r_drop;
                        n_out.last           = 1'b0;
                        n_cnum               = r_cnum + 1'b1;
                        ctl.shift   = 1'b1;
                        n_count     = r_count - 1'b1;
                        n_wend      = {1'b0, head.hit_time} + {1'b0, r_window};
                        n_acc_time  = head.hit_time;
                        n_acc_track = head.track;
                        n_acc_sum   = {{(SumW - DepW){1'b0}}, head.deposit};
                    end
                end else if (!r_acc_on) begin
                    n_drop = 1'b0;
                end else if (out_free) begin
                    n_ovalid             = 1'b1;
                    n_out.cluster_number = r_cnum;
                    n_out.cluster_time   = r_acc_time;
                    n_out.top_track      = r_acc_track;
                    n_out.deposit_sum    = r_acc_sum;
                    n_out.overflow       = r_drop;
                    n_out.last           = 1'b1;
                    n_acc_on             = 1'b0;
                    n_drop               = 1'b0;
                end
            end
            default: begin
                n_acc_on = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_drop   <= 1'b0;
            r_acc_on <= 1'b0;
            r_cnum   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_drop   <= n_drop;
            r_acc_on <= n_acc_on;
            r_cnum   <= n_cnum;
            r_ovalid <= n_ovalid;
        end
        r_wend      <= n_wend;
        r_acc_time  <= n_acc_time;
        r_acc_track <= n_acc_track;
        r_acc_sum   <= n_acc_sum;
        r_out       <= n_out;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountW'(MAX_HITS))
        else $error("fill count above store depth");
    a_eoe_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_item.func == FuncEnd) |=> (r_state == ST_DRAIN))
        else $error("end of event did not start a drain");
    a_head_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (head.valid == (r_count != '0)))
        else $error("chain head disagrees with fill count");
`endif

endmodule

// ----- src/dhtc_cell.sv -----
// One slot of the time-sorted hit chain.
// Depends on dhtc_pkg.
`timescale 1ns / 1ps
module dhtc_cell
    import dhtc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_chain_ctl i_ctl,
    input  t_hit       i_new,
    input  t_hit       i_prev,
    input  logic       i_prev_after,
    input  t_hit       i_next,
    output t_hit       o_hit,
    output logic       o_after
);

    t_hit r_hit;
    t_hit n_hit;

    // new hit sorts behind this one (ties keep arrival order)
    assign o_after = r_hit.valid && (r_hit.hit_time <= i_new.hit_time);

    always_comb begin
        n_hit = r_hit;
        if (i_ctl.shift) begin
            n_hit = i_next;
        end else if (i_ctl.ins && !o_after) begin
            n_hit = i_prev_after ? i_new : i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit.valid <= 1'b0;
        end else begin
            r_hit.valid <= n_hit.valid;
        end
        r_hit.hit_time <= n_hit.hit_time;
        r_hit.deposit  <= n_hit.deposit;
        r_hit.track    <= n_hit.track;
    end

    assign o_hit = r_hit;

endmodule

// ----- src/dhtc_chain.sv -----
// Row of sorting cells: inserts hits in time order, shifts toward the head on drain.
// Depends on dhtc_pkg and dhtc_cell.
`timescale 1ns / 1ps
module dhtc_chain
    import dhtc_pkg::*;
#(
    parameter int unsigned Depth = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_chain_ctl i_ctl,
    input  t_hit       i_new,
    output t_hit       o_head
);

    t_hit hits  [Depth];
    logic after [Depth];
    t_hit empty_hit;

    always_comb begin
        empty_hit = i_new;
        empty_hit.valid = 1'b0;
    end

    for (genvar g = 0; g < Depth; g++) begin : g_cell
        t_hit prev_hit;
        t_hit next_hit;
        logic prev_after;
        if (g == 0) begin : g_first
            assign prev_hit   = i_new;
            assign prev_after = 1'b1;
        end else begin : g_mid
            assign prev_hit   = hits[g-1];
            assign prev_after = after[g-1];
        end
        if (g == Depth - 1) begin : g_tail
            assign next_hit = empty_hit;
        end else begin : g_body
            assign next_hit = hits[g+1];
        end
        dhtc_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (i_ctl),
            .i_new       (i_new),
            .i_prev      (prev_hit),
            .i_prev_after(prev_after),
            .i_next      (next_hit),
            .o_hit       (hits[g]),
            .o_after     (after[g])
        );
    end

    assign o_head = hits[0];

endmodule
